@@ rtl/core/bierb_pkg.sv @@
package bierb_pkg;

  // defaults for the top-level parameters
  localparam int unsigned StoreBytesDef = 4096;
  localparam int unsigned GapSlackDef   = 8;

  // fixed field widths
  localparam int unsigned OpW    = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 13;
  localparam int unsigned ElemW  = 4;
  localparam int unsigned DataW  = 64;
  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;

  localparam logic [ElemW-1:0] ElemBytesRst = 4'd8;
  localparam logic [LenW-1:0]  MaxBlockRst  = 13'd1024;
  localparam logic [ElemW-1:0] ElemBytesMax = 4'd8;

  // register select, taken from paddr[2]
  localparam logic RegElemBytes = 1'b0;
  localparam logic RegMaxBlock  = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_BEGIN = 3'd0,
    OP_WRITE = 3'd1,
    OP_END   = 3'd2,
    OP_READ  = 3'd3,
    OP_FILL  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_OVERFLOW   = 2'd1,
    ERR_FILL_STATE = 2'd2,
    ERR_EMPTY      = 2'd3
  } err_e;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             valid;
    logic [ElemW-1:0] count;
    logic             empty;
    err_e             err;
  } result_t;

  typedef struct packed {
    logic accept;
    logic rd_step;
    logic load_fill;
    logic fill_step;
    logic mv_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic go_read;
    logic go_fill;
    logic go_move;
    logic last;
  } status_t;

endpackage

@@ rtl/core/block_in_element_out_ring_buffer.sv @@
// Write byte, end block, begin block without a gap move, empty or zero-length reads:
//   one request per cycle while the queue has room, result queued the cycle after acceptance.
// Read of k bytes: one registered store read port, an issue and a wait state per byte.
// Fill: read one element, write it n times from zero; gap move: a read and a write per byte (one store port pair).
// Reset: all pointers zero, element_bytes 8, max_block_bytes 1024, output queue empty;
//   store contents stay undefined, no clearing pass.
module block_in_element_out_ring_buffer #(
  parameter int unsigned STORE_BYTES = bierb_pkg::StoreBytesDef,
  parameter int unsigned GAP_SLACK   = bierb_pkg::GapSlackDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bierb_pkg::OpW-1:0]     op_i,
  input  logic [bierb_pkg::ByteW-1:0]   data_byte_i,
  input  logic [bierb_pkg::LenW-1:0]    block_length_i,
  input  logic [bierb_pkg::LenW-1:0]    fill_count_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bierb_pkg::DataW-1:0]   element_data_o,
  output logic                          element_valid_o,
  output logic [bierb_pkg::ElemW-1:0]   element_count_bytes_o,
  output logic                          empty_flag_o,
  output logic [1:0]                    error_code_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bierb_pkg::PAddrW-1:0]  paddr,
  input  logic [bierb_pkg::PDataW-1:0]  pwdata,
  output logic [bierb_pkg::PDataW-1:0]  prdata,
  output logic                          pready
);
  import bierb_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t push_data, head;
  logic    push, room, cfg_we;

  // no wait states; a write lands on the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // sequencer: one request at a time, loops over store bytes
  bierb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .room_i     (room),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // pointers, store and element assembly
  bierb_dp #(
    .STORE_BYTES (STORE_BYTES),
    .GAP_SLACK   (GAP_SLACK)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op_i),
    .data_byte_i    (data_byte_i),
    .block_length_i (block_length_i),
    .fill_count_i   (fill_count_i),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (paddr),
    .cfg_wdata_i    (pwdata),
    .cfg_rdata_o    (prdata),
    .cmd_i          (cmd),
    .status_o       (status),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  // two-deep result queue decouples the consumer's stalls
  bierb_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign element_data_o        = head.data;
  assign element_valid_o       = head.valid;
  assign element_count_bytes_o = head.count;
  assign empty_flag_o          = head.empty;
  assign error_code_o          = head.err;

endmodule

@@ rtl/core/bierb_ctrl.sv @@
module bierb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               room_i,
  input  bierb_pkg::status_t status_i,
  output logic               in_ready_o,
  output bierb_pkg::cmd_t    cmd_o
);
  import bierb_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_RD_ISSUE = 7'b0000010,
    ST_RD_WAIT  = 7'b0000100,
    ST_FILL_WR  = 7'b0001000,
    ST_MV_RD    = 7'b0010000,
    ST_MV_WR    = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   fill_q, fill_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && room_i;
  assign accept     = in_ready_o && in_valid_i;
  assign fill_d     = accept ? status_i.go_fill : fill_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.go_read || status_i.go_fill) state_d = ST_RD_ISSUE;
          else if (status_i.go_move)                state_d = ST_MV_RD;
        end
      end
      ST_RD_ISSUE: state_d = ST_RD_WAIT;
      ST_RD_WAIT: begin
        if (status_i.last) state_d = fill_q ? ST_FILL_WR : ST_DONE;
        else               state_d = ST_RD_ISSUE;
      end
      ST_FILL_WR: begin
        if (status_i.last) state_d = ST_DONE;
      end
      ST_MV_RD: state_d = ST_MV_WR;
      ST_MV_WR: begin
        state_d = status_i.last ? ST_DONE : ST_MV_RD;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_comb begin
    cmd_o.accept    = accept;
    cmd_o.rd_step   = (state_q == ST_RD_WAIT);
    cmd_o.load_fill = (state_q == ST_RD_WAIT) && status_i.last && fill_q;
    cmd_o.fill_step = (state_q == ST_FILL_WR);
    cmd_o.mv_step   = (state_q == ST_MV_WR);
    cmd_o.finish    = (state_q == ST_DONE);
  end

endmodule

@@ rtl/core/bierb_dp.sv @@
module bierb_dp #(
  parameter int unsigned STORE_BYTES = bierb_pkg::StoreBytesDef,
  parameter int unsigned GAP_SLACK   = bierb_pkg::GapSlackDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bierb_pkg::OpW-1:0]      op_i,
  input  logic [bierb_pkg::ByteW-1:0]    data_byte_i,
  input  logic [bierb_pkg::LenW-1:0]     block_length_i,
  input  logic [bierb_pkg::LenW-1:0]     fill_count_i,
  input  logic                           cfg_we_i,
  input  logic [bierb_pkg::PAddrW-1:0]   cfg_addr_i,
  input  logic [bierb_pkg::PDataW-1:0]   cfg_wdata_i,
  output logic [bierb_pkg::PDataW-1:0]   cfg_rdata_o,
  input  bierb_pkg::cmd_t                cmd_i,
  output bierb_pkg::status_t             status_o,
  output logic                           push_o,
  output bierb_pkg::result_t             push_data_o
);
  import bierb_pkg::*;

  localparam int unsigned PW = $clog2(STORE_BYTES + 1);
  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned BW = (PW > LenW + ElemW) ? PW : LenW + ElemW;
  localparam int unsigned WW = BW + 2;
  localparam logic [WW-1:0] StoreW = WW'(STORE_BYTES);
  localparam logic [WW-1:0] SlackW = WW'(GAP_SLACK);

  // pointers and configuration
  logic [PW-1:0]    insert_start_q, data_end_q, read_pos_q, upper_top_q, write_offset_q;
  logic [PW-1:0]    insert_start_d, data_end_d, read_pos_d, upper_top_d, write_offset_d;
  logic [ElemW-1:0] elem_bytes_q;
  logic [LenW-1:0]  max_block_q;

  // loop state
  logic [PW-1:0]    addr_q, cnt_q, delta_q;
  logic [2:0]       idx_q;
  logic [DataW-1:0] elem_q;
  logic             res_valid_q, res_empty_q;
  logic [ElemW-1:0] res_count_q;
  err_e             res_err_q;

  // store
  logic [7:0]    mem_q [STORE_BYTES];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [PW-1:0] mv_waddr;

  logic [ElemW-1:0] es, cnt_r;
  logic [WW-1:0]    is_w, de_w, rp_w, top_w, wo_w, maxb_w;
  logic [WW-1:0]    sum_a, end_a, gap, delta_w, rp1, top1, avail, prod;
  logic             wr_en, go_read, go_fill, go_move, r_valid, empty;
  logic [ElemW-1:0] r_count;
  err_e             err;
  logic [PW-1:0]    loop_addr, loop_cnt;

  always_comb begin
    if (elem_bytes_q == '0)              es = 4'd1;
    else if (elem_bytes_q > ElemBytesMax) es = ElemBytesMax;
    else                                 es = elem_bytes_q;
  end

  assign is_w    = WW'(insert_start_q);
  assign de_w    = WW'(data_end_q);
  assign rp_w    = WW'(read_pos_q);
  assign top_w   = WW'(upper_top_q);
  assign wo_w    = WW'(write_offset_q);
  assign maxb_w  = WW'(max_block_q);
  assign sum_a   = is_w + wo_w;
  assign end_a   = is_w + WW'(block_length_i);
  assign gap     = rp_w - de_w;
  assign delta_w = maxb_w - gap + SlackW;
  assign prod    = WW'(fill_count_i) * WW'(es);

  always_comb begin
    insert_start_d = insert_start_q;
    data_end_d     = data_end_q;
    read_pos_d     = read_pos_q;
    upper_top_d    = upper_top_q;
    write_offset_d = write_offset_q;
    err       = ERR_NONE;
    r_valid   = 1'b0;
    r_count   = '0;
    go_read   = 1'b0;
    go_fill   = 1'b0;
    go_move   = 1'b0;
    wr_en     = 1'b0;
    loop_addr = '0;
    loop_cnt  = '0;
    rp1       = '0;
    top1      = '0;
    avail     = '0;
    cnt_r     = '0;
    unique case (op_i)
      OP_BEGIN: begin
        insert_start_d = data_end_q;
        write_offset_d = '0;
        if (rp_w <= de_w) begin
          if (rp_w > maxb_w)                insert_start_d = '0;
          else if (de_w + maxb_w > StoreW) err = ERR_OVERFLOW;
        end else if (gap <= maxb_w) begin
          // reader sits in a tight gap: shift the upper run up
          if (top_w > StoreW || top_w + delta_w > StoreW || top_w < rp_w) begin
            err = ERR_OVERFLOW;
          end else begin
            read_pos_d  = PW'(rp_w + delta_w);
            upper_top_d = PW'(top_w + delta_w);
            go_move     = (top_w != rp_w);
            loop_addr   = PW'(top_w - WW'(1));
            loop_cnt    = PW'(top_w - rp_w);
          end
        end
      end
      OP_WRITE: begin
        if (sum_a < StoreW) begin
          wr_en          = 1'b1;
          write_offset_d = write_offset_q + PW'(1);
        end else begin
          err = ERR_OVERFLOW;
        end
      end
      OP_END: begin
        if (block_length_i != '0) begin
          if (end_a > StoreW) begin
            err = ERR_OVERFLOW;
          end else begin
            data_end_d = PW'(end_a);
            if (rp_w <= end_a) upper_top_d = PW'(end_a);
          end
        end
      end
      OP_READ: begin
        if (read_pos_q == data_end_q) begin
          err = ERR_EMPTY;
        end else begin
          rp1   = (read_pos_q == upper_top_q) ? '0 : rp_w;
          top1  = (read_pos_q == upper_top_q) ? de_w : top_w;
          avail = (top1 > rp1) ? top1 - rp1 : '0;
          cnt_r = (avail < WW'(es)) ? avail[ElemW-1:0] : es;
          upper_top_d = PW'(top1);
          read_pos_d  = PW'(rp1 + WW'(cnt_r));
          r_valid     = 1'b1;
          r_count     = cnt_r;
          go_read     = (cnt_r != '0);
          loop_addr   = PW'(rp1);
          loop_cnt    = PW'(cnt_r);
        end
      end
      OP_FILL: begin
        if (de_w < rp_w || de_w - rp_w != WW'(es)) begin
          err = ERR_FILL_STATE;
        end else if (prod > StoreW) begin
          err = ERR_OVERFLOW;
        end else begin
          insert_start_d = '0;
          write_offset_d = '0;
          read_pos_d     = '0;
          data_end_d     = PW'(prod);
          upper_top_d    = PW'(prod);
          go_fill        = (fill_count_i != '0);
          loop_addr      = read_pos_q;
          loop_cnt       = PW'(es);
        end
      end
      default: ;
    endcase
    empty = (read_pos_d == data_end_d);
  end

  assign status_o.go_read = go_read;
  assign status_o.go_fill = go_fill;
  assign status_o.go_move = go_move;
  assign status_o.last    = (cnt_q == PW'(1));

  assign push_o = (cmd_i.accept && !(go_read || go_fill || go_move)) || cmd_i.finish;

  always_comb begin
    if (cmd_i.accept) begin
      push_data_o.data  = '0;
      push_data_o.valid = r_valid;
      push_data_o.count = r_count;
      push_data_o.empty = empty;
      push_data_o.err   = err;
    end else begin
      push_data_o.data  = res_valid_q ? elem_q : '0;
      push_data_o.valid = res_valid_q;
      push_data_o.count = res_count_q;
      push_data_o.empty = res_empty_q;
      push_data_o.err   = res_err_q;
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_bytes_q <= ElemBytesRst;
      max_block_q  <= MaxBlockRst;
    end else if (cfg_we_i) begin
      if (cfg_addr_i[2] == RegElemBytes) elem_bytes_q <= cfg_wdata_i[ElemW-1:0];
      else                               max_block_q  <= cfg_wdata_i[LenW-1:0];
    end
  end

  assign cfg_rdata_o = (cfg_addr_i[2] == RegMaxBlock) ? PDataW'(max_block_q)
                                                      : PDataW'(elem_bytes_q);

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      insert_start_q <= '0;
      data_end_q     <= '0;
      read_pos_q     <= '0;
      upper_top_q    <= '0;
      write_offset_q <= '0;
    end else if (cfg_we_i) begin
      insert_start_q <= '0;
      data_end_q     <= '0;
      read_pos_q     <= '0;
      upper_top_q    <= '0;
      write_offset_q <= '0;
    end else if (cmd_i.accept) begin
      insert_start_q <= insert_start_d;
      data_end_q     <= data_end_d;
      read_pos_q     <= read_pos_d;
      upper_top_q    <= upper_top_d;
      write_offset_q <= write_offset_d;
    end
  end

  // byte loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      delta_q <= '0;
    end else if (cmd_i.accept) begin
      addr_q  <= loop_addr;
      cnt_q   <= loop_cnt;
      idx_q   <= '0;
      delta_q <= PW'(delta_w);
    end else if (cmd_i.load_fill) begin
      addr_q <= '0;
      cnt_q  <= data_end_q;
      idx_q  <= '0;
    end else if (cmd_i.rd_step) begin
      addr_q <= addr_q + PW'(1);
      cnt_q  <= cnt_q - PW'(1);
      idx_q  <= idx_q + 3'd1;
    end else if (cmd_i.fill_step) begin
      addr_q <= addr_q + PW'(1);
      cnt_q  <= cnt_q - PW'(1);
      idx_q  <= (idx_q == 3'(es - 4'd1)) ? 3'd0 : idx_q + 3'd1;
    end else if (cmd_i.mv_step) begin
      addr_q <= addr_q - PW'(1);
      cnt_q  <= cnt_q - PW'(1);
    end
  end

  // element buffer and held result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      elem_q      <= '0;
      res_valid_q <= r_valid;
      res_count_q <= r_count;
      res_empty_q <= empty;
      res_err_q   <= err;
    end else if (cmd_i.rd_step) begin
      elem_q[{idx_q, 3'b000} +: 8] <= rdata_q;
    end
  end

  assign mv_waddr = addr_q + delta_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q[AW-1:0];
    mem_wdata = rdata_q;
    if (cmd_i.accept && wr_en) begin
      mem_we    = 1'b1;
      mem_waddr = sum_a[AW-1:0];
      mem_wdata = data_byte_i;
    end else if (cmd_i.fill_step) begin
      mem_we    = 1'b1;
      mem_wdata = elem_q[{idx_q, 3'b000} +: 8];
    end else if (cmd_i.mv_step) begin
      mem_we    = 1'b1;
      mem_waddr = mv_waddr[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[addr_q[AW-1:0]];
  end

endmodule

@@ rtl/core/bierb_outq.sv @@
module bierb_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bierb_pkg::result_t push_data_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bierb_pkg::result_t head_o
);
  import bierb_pkg::*;

  result_t    ent0_q, ent1_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign room_o      = (cnt_q != 2'd2);
  assign head_o      = ent0_q;
  assign cnt_d       = cnt_q + 2'(push_i) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= 2'd0;
    else         cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop && cnt_q == 2'd2) begin
      ent0_q <= ent1_q;
      if (push_i) ent1_q <= push_data_i;
    end else if (pop) begin
      if (push_i) ent0_q <= push_data_i;
    end else if (push_i) begin
      if (cnt_q == 2'd0) ent0_q <= push_data_i;
      else               ent1_q <= push_data_i;
    end
  end

endmodule

@@ rtl/core/bierb_checker.sv @@
module bierb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [bierb_pkg::DataW-1:0] element_data_o,
  input logic                        element_valid_o,
  input logic [bierb_pkg::ElemW-1:0] element_count_bytes_o,
  input logic [1:0]                  error_code_o
);
  import bierb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(element_data_o)
                                    && $stable(error_code_o))
    else $error("result changed while stalled");

  a_valid_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && element_valid_o |-> error_code_o == ERR_NONE)
    else $error("element returned with an error");

  a_no_elem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !element_valid_o |->
      element_count_bytes_o == '0 && element_data_o == '0)
    else $error("non-read result carries data");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> element_count_bytes_o <= ElemBytesMax)
    else $error("element byte count too large");

endmodule

bind block_in_element_out_ring_buffer bierb_checker u_checker (.*);
